FILE: hw/rtl/hsif_pkg.sv
// ----------------------------------------------------------------------------
// Hot strip finder package
// Shared constants, register codes and beat types of the hot strip finder.
// ----------------------------------------------------------------------------
package hsif_pkg;

	localparam int CFG_W         = 10;
	localparam int OCC_W         = 16;
	localparam int THR_W         = 16;
	localparam int FLAG_W        = 64;
	localparam int WIDX_W        = 4;
	localparam int HCNT_W        = 10;
	localparam int REL_FRAC_BITS = 8;

	localparam int DEF_MAX_STRIPS = 768;
	localparam int DEF_WORD_BITS  = 64;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic [CFG_W-1:0] RST_STRIPS_IN_USE = 10'd768;
	localparam logic [CFG_W-1:0] RST_SECTOR_SIZE   = 10'd768;
	localparam logic [THR_W-1:0] RST_ABS_THRESHOLD = 16'd13107;
	localparam logic [THR_W-1:0] RST_REL_FACTOR    = 16'd1280;

	localparam logic [1:0] REG_STRIPS_IN_USE = 2'd0;
	localparam logic [1:0] REG_SECTOR_SIZE   = 2'd1;
	localparam logic [1:0] REG_ABS_THRESHOLD = 2'd2;
	localparam logic [1:0] REG_REL_FACTOR    = 2'd3;

	typedef struct packed {
		logic [OCC_W-1:0] occupancy;
		logic             last_strip;
	} strip_t;

	typedef struct packed {
		logic [FLAG_W-1:0] flag_word;
		logic [WIDX_W-1:0] word_index;
		logic [HCNT_W-1:0] hot_count;
		logic              last_word;
	} flag_t;

endpackage

FILE: hw/rtl/hsif_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hsif_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hw/rtl/hsif_mul_cmp.sv
// ----------------------------------------------------------------------------
// Shared multiply and compare unit
// Forms one product and compares it, shifted left by the eight fraction bits of the Q8.8 factor, with a bound.
// ----------------------------------------------------------------------------
module hsif_mul_cmp #(
	parameter int A_W = 26,
	parameter int B_W = 16
) (
	input  logic [A_W-1:0]     a,
	input  logic [B_W-1:0]     b,
	input  logic [A_W+B_W-1:0] bound,
	output logic [A_W+B_W-1:0] product,
	output logic               gt
);
	import hsif_pkg::*;

	localparam int PW = A_W + B_W;

	logic [PW+REL_FRAC_BITS-1:0] scaled;
	logic [PW+REL_FRAC_BITS-1:0] bound_x;

	assign product = PW'(a) * PW'(b);
	assign scaled  = {product, {REL_FRAC_BITS{1'b0}}};
	assign bound_x = (PW + REL_FRAC_BITS)'(bound);
	assign gt      = scaled > bound_x;

endmodule

FILE: hw/rtl/hot_strip_iterative_finder_core.sv
// ----------------------------------------------------------------------------
// Hot strip iterative finder core
// Stores strip occupancies of one sensor side and flags hot strips.
// ----------------------------------------------------------------------------
// Strips load one beat per cycle into a strip memory. The beat that carries
// last_strip starts a run, during which no strip is taken: an absolute pass,
// then repeated relative passes, where each whole sector is first summed and,
// if it has a nonzero strip, then judged, and each pass closes in S_NEXT, all
// through the single read port of the strip memory and one shared multiplier.
// The run ends with one flag beat per WORD_BITS strips, each gathered in
// S_EMIT and moved into an output register from S_OUT, later if the previous
// beat still waits for the receiver.
module hot_strip_iterative_finder_core #(
	parameter int MAX_STRIPS = hsif_pkg::DEF_MAX_STRIPS,
	parameter int WORD_BITS  = hsif_pkg::DEF_WORD_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                strip_valid,
	output logic                                strip_ready,
	input  hsif_pkg::strip_t                    strip,
	output logic                                flag_valid,
	input  logic                                flag_ready,
	output hsif_pkg::flag_t                     flag,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [hsif_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [hsif_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [hsif_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready
);
	import hsif_pkg::*;

	localparam int IW    = $clog2(MAX_STRIPS + 1);
	localparam int AW    = $clog2(MAX_STRIPS);
	localparam int PW    = ((IW > CFG_W) ? IW : CFG_W) + 1;
	localparam int SW    = OCC_W + IW;
	localparam int PRW   = SW + THR_W;
	localparam int RAM_W = OCC_W + 1;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ABS   = 3'd1;
	localparam logic [2:0] S_NEXT  = 3'd2;
	localparam logic [2:0] S_SUM   = 3'd3;
	localparam logic [2:0] S_RHS   = 3'd4;
	localparam logic [2:0] S_JUDGE = 3'd5;
	localparam logic [2:0] S_EMIT  = 3'd6;
	localparam logic [2:0] S_OUT   = 3'd7;

	logic [CFG_W-1:0] strips_in_use_q;
	logic [CFG_W-1:0] sector_size_q;
	logic [THR_W-1:0] abs_threshold_q;
	logic [THR_W-1:0] rel_factor_q;

	logic [2:0]           state_q;
	logic [IW-1:0]        cnt_q;
	logic [PW-1:0]        n_q;
	logic [PW-1:0]        base_q;
	logic [PW-1:0]        first_q;
	logic [PW-1:0]        addr_q;
	logic [PW-1:0]        end_q;
	logic [PW-1:0]        wbase_q;
	logic                 rd_pend_s1;
	logic [PW-1:0]        rd_pos_s1;
	logic [SW-1:0]        sum_q;
	logic [IW-1:0]        nz_q;
	logic [PRW-1:0]       rhs_q;
	logic                 found_q;
	logic [IW-1:0]        total_q;
	logic [WORD_BITS-1:0] word_q;
	logic [WIDX_W-1:0]    widx_q;
	logic                 flag_valid_q;
	flag_t                flag_q;

	logic             cfg_wr;
	logic             strip_fire;
	logic [PW-1:0]    n_ext;
	logic [PW-1:0]    n_w;
	logic [PW-1:0]    base_w;
	logic             sweeping;
	logic             issue;
	logic             sweep_done;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [RAM_W-1:0] ram_wdata;
	logic [RAM_W-1:0] ram_rdata;
	logic [OCC_W-1:0] rd_occ;
	logic             rd_hot;
	logic             abs_hot;
	logic [SW-1:0]    mul_a;
	logic [THR_W-1:0] mul_b;
	logic [PRW-1:0]   mul_p;
	logic             mul_gt;
	logic             word_last;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strips_in_use_q <= RST_STRIPS_IN_USE;
			sector_size_q   <= RST_SECTOR_SIZE;
			abs_threshold_q <= RST_ABS_THRESHOLD;
			rel_factor_q    <= RST_REL_FACTOR;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_STRIPS_IN_USE: strips_in_use_q <= pwdata[CFG_W-1:0];
				REG_SECTOR_SIZE:   sector_size_q   <= pwdata[CFG_W-1:0];
				REG_ABS_THRESHOLD: abs_threshold_q <= pwdata[THR_W-1:0];
				REG_REL_FACTOR:    rel_factor_q    <= pwdata[THR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_STRIPS_IN_USE: prdata = APB_DATA_W'(strips_in_use_q);
			REG_SECTOR_SIZE:   prdata = APB_DATA_W'(sector_size_q);
			REG_ABS_THRESHOLD: prdata = APB_DATA_W'(abs_threshold_q);
			REG_REL_FACTOR:    prdata = APB_DATA_W'(rel_factor_q);
			default:           prdata = '0;
		endcase
	end

	assign strip_ready = (state_q == S_IDLE);
	assign strip_fire  = strip_valid && strip_ready;

	assign n_ext  = PW'(strips_in_use_q);
	assign n_w    = (n_ext > PW'(MAX_STRIPS)) ? PW'(MAX_STRIPS) : n_ext;
	assign base_w = (sector_size_q == '0) ? n_w : PW'(sector_size_q);

	assign sweeping   = (state_q == S_ABS) || (state_q == S_SUM) ||
	                    (state_q == S_JUDGE) || (state_q == S_EMIT);
	assign issue      = sweeping && (addr_q < end_q);
	assign sweep_done = sweeping && !(addr_q < end_q) && !rd_pend_s1;

	assign rd_occ  = ram_rdata[OCC_W-1:0];
	assign rd_hot  = ram_rdata[OCC_W];
	assign abs_hot = rd_occ > abs_threshold_q;

	assign mul_a = (state_q == S_RHS) ? sum_q : SW'(nz_q);
	assign mul_b = (state_q == S_RHS) ? rel_factor_q : rd_occ;

	assign word_last = (wbase_q + PW'(WORD_BITS)) >= n_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = rd_pos_s1[AW-1:0];
		ram_wdata = '0;
		case (state_q)
			S_IDLE: begin
				ram_we    = strip_fire && (cnt_q < IW'(MAX_STRIPS));
				ram_waddr = cnt_q[AW-1:0];
				ram_wdata = {1'b0, strip.occupancy};
			end
			S_ABS: begin
				ram_we    = rd_pend_s1;
				ram_wdata = abs_hot ? {1'b1, {OCC_W{1'b0}}} : {1'b0, rd_occ};
			end
			S_JUDGE: begin
				ram_we    = rd_pend_s1 && mul_gt;
				ram_wdata = {1'b1, {OCC_W{1'b0}}};
			end
			default: begin
			end
		endcase
	end

	hsif_ram #(
		.WIDTH(RAM_W),
		.DEPTH(MAX_STRIPS)
	) u_strip_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(addr_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	hsif_mul_cmp #(
		.A_W(SW),
		.B_W(THR_W)
	) u_mul_cmp (
		.a      (mul_a),
		.b      (mul_b),
		.bound  (rhs_q),
		.product(mul_p),
		.gt     (mul_gt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			n_q          <= '0;
			base_q       <= '0;
			first_q      <= '0;
			addr_q       <= '0;
			end_q        <= '0;
			wbase_q      <= '0;
			rd_pend_s1   <= 1'b0;
			rd_pos_s1    <= '0;
			sum_q        <= '0;
			nz_q         <= '0;
			rhs_q        <= '0;
			found_q      <= 1'b0;
			total_q      <= '0;
			word_q       <= '0;
			widx_q       <= '0;
			flag_valid_q <= 1'b0;
		end else begin
			rd_pend_s1 <= issue;
			rd_pos_s1  <= addr_q;
			if (issue) begin
				addr_q <= addr_q + PW'(1);
			end
			if (state_q == S_OUT && (!flag_valid_q || flag_ready)) begin
				flag_valid_q <= 1'b1;
			end else if (flag_ready) begin
				flag_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (strip_fire) begin
						if (cnt_q < IW'(MAX_STRIPS)) begin
							cnt_q <= cnt_q + IW'(1);
						end
						if (strip.last_strip) begin
							n_q     <= n_w;
							base_q  <= base_w;
							total_q <= '0;
							addr_q  <= '0;
							end_q   <= n_w;
							state_q <= S_ABS;
						end
					end
				end
				S_ABS: begin
					if (rd_pend_s1 && abs_hot) begin
						total_q <= total_q + IW'(1);
					end
					if (sweep_done) begin
						first_q <= '0;
						found_q <= 1'b0;
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					if (base_q != '0 && (first_q + base_q) <= n_q) begin
						addr_q  <= first_q;
						end_q   <= first_q + base_q;
						sum_q   <= '0;
						nz_q    <= '0;
						state_q <= S_SUM;
					end else if (found_q) begin
						first_q <= '0;
						found_q <= 1'b0;
					end else begin
						wbase_q <= '0;
						widx_q  <= '0;
						addr_q  <= '0;
						end_q   <= PW'(WORD_BITS);
						state_q <= S_EMIT;
					end
				end
				S_SUM: begin
					if (rd_pend_s1) begin
						sum_q <= sum_q + SW'(rd_occ);
						if (rd_occ != '0) begin
							nz_q <= nz_q + IW'(1);
						end
					end
					if (sweep_done) begin
						if (nz_q == '0) begin
							first_q <= first_q + base_q;
							state_q <= S_NEXT;
						end else begin
							state_q <= S_RHS;
						end
					end
				end
				S_RHS: begin
					rhs_q   <= mul_p;
					addr_q  <= first_q;
					end_q   <= first_q + base_q;
					state_q <= S_JUDGE;
				end
				S_JUDGE: begin
					if (rd_pend_s1 && mul_gt) begin
						found_q <= 1'b1;
						total_q <= total_q + IW'(1);
					end
					if (sweep_done) begin
						first_q <= first_q + base_q;
						state_q <= S_NEXT;
					end
				end
				S_EMIT: begin
					if (rd_pend_s1) begin
						word_q <= {rd_hot && (rd_pos_s1 < n_q), word_q[WORD_BITS-1:1]};
					end
					if (sweep_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!flag_valid_q || flag_ready) begin
						if (word_last) begin
							cnt_q   <= '0;
							state_q <= S_IDLE;
						end else begin
							wbase_q <= wbase_q + PW'(WORD_BITS);
							widx_q  <= widx_q + WIDX_W'(1);
							addr_q  <= wbase_q + PW'(WORD_BITS);
							end_q   <= wbase_q + PW'(2 * WORD_BITS);
							state_q <= S_EMIT;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!flag_valid_q || flag_ready)) begin
			flag_q.flag_word  <= FLAG_W'(word_q);
			flag_q.word_index <= widx_q;
			flag_q.hot_count  <= HCNT_W'(total_q);
			flag_q.last_word  <= word_last;
		end
	end

	assign flag_valid = flag_valid_q;
	assign flag       = flag_q;

`ifndef SYNTHESIS
	a_pend_same_phase: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> (state_q == $past(state_q)))
		else $error("strip memory read data arrived after its phase ended");

	a_write_phases: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_IDLE || state_q == S_ABS || state_q == S_JUDGE))
		else $error("strip memory written outside load or flagging phases");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (total_q <= IW'(n_q)))
		else $error("hot strip count exceeds the strips in use");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= IW'(MAX_STRIPS))
		else $error("strip counter beyond memory depth");

	a_flag_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(flag_valid && !flag_ready) |=> (flag_valid && $stable(flag)))
		else $error("flag beat changed while waiting for the receiver");
`endif

endmodule

FILE: tb/sv/hsif_flag_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hot strip finder flag checker
// Watches the strip, flag and register ports of the hot strip finder. It keeps
// its own copy of the strip memory and of the registers, judges every side when
// its final strip beat is taken, queues the flag beats that the side must
// produce and compares each flag beat that leaves the block with the oldest of
// them. Register reads are compared with the last value written.
// ----------------------------------------------------------------------------
module hsif_flag_checker #(
	parameter int MAX_STRIPS = hsif_pkg::DEF_MAX_STRIPS,
	parameter int WORD_BITS  = hsif_pkg::DEF_WORD_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            strip_valid,
	input  logic                            strip_ready,
	input  hsif_pkg::strip_t                strip,
	input  logic                            flag_valid,
	input  logic                            flag_ready,
	input  hsif_pkg::flag_t                 flag,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [hsif_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [hsif_pkg::APB_DATA_W-1:0] pwdata,
	input  logic [hsif_pkg::APB_DATA_W-1:0] prdata,
	input  logic                            pready,
	output int unsigned                     mismatch_count,
	output int unsigned                     flags_pending,
	output int unsigned                     sides_judged,
	output int unsigned                     words_checked
);
	import hsif_pkg::*;

	logic [OCC_W-1:0]      side_occ [MAX_STRIPS];
	logic                  side_hot [MAX_STRIPS];
	int unsigned           load_count;
	logic [CFG_W-1:0]      cfg_strips;
	logic [CFG_W-1:0]      cfg_sector;
	logic [THR_W-1:0]      cfg_abs;
	logic [THR_W-1:0]      cfg_rel;
	logic [APB_DATA_W-1:0] reg_readback;
	flag_t                 flag_expect_q [$];
	flag_t                 want;

	function automatic void check_field(input string field, input logic [63:0] exp_val,
			input logic [63:0] got_val);
		if (got_val !== exp_val) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, exp_val, got_val);
			mismatch_count++;
		end
	endfunction

	// One relative pass over the whole sectors of the side.
	function automatic bit sector_pass(input int unsigned n, input int unsigned base);
		bit              found;
		int unsigned     first;
		longint unsigned sum;
		longint unsigned cnt;
		longint unsigned rhs;
		longint unsigned lhs;
		found = 1'b0;
		for (int unsigned s = 0; s < n / base; s++) begin
			first = s * base;
			sum = 0;
			cnt = 0;
			for (int unsigned l = first; l < first + base; l++) begin
				sum += side_occ[l];
				if (side_occ[l] != '0) begin
					cnt++;
				end
			end
			if (cnt != 0) begin
				rhs = sum * 64'(cfg_rel);
				for (int unsigned l = first; l < first + base; l++) begin
					lhs = 64'(side_occ[l]) * cnt * 64'd256;
					if (lhs > rhs) begin
						side_hot[l] = 1'b1;
						side_occ[l] = '0;
						found = 1'b1;
					end
				end
			end
		end
		return found;
	endfunction

	function automatic void judge_side();
		int unsigned n;
		int unsigned base;
		int unsigned hot_total;
		int unsigned words;
		bit          again;
		flag_t       beat;
		n = (cfg_strips > MAX_STRIPS) ? MAX_STRIPS : cfg_strips;
		base = (cfg_sector == '0) ? n : cfg_sector;
		for (int i = 0; i < MAX_STRIPS; i++) begin
			side_hot[i] = 1'b0;
		end
		for (int unsigned l = 0; l < n; l++) begin
			if (side_occ[l] > cfg_abs) begin
				side_hot[l] = 1'b1;
				side_occ[l] = '0;
			end
		end
		if (base != 0) begin
			again = 1'b1;
			while (again) begin
				again = sector_pass(n, base);
			end
		end
		hot_total = 0;
		for (int unsigned l = 0; l < n; l++) begin
			hot_total += side_hot[l];
		end
		words = (n + WORD_BITS - 1) / WORD_BITS;
		if (words == 0) begin
			words = 1;
		end
		for (int unsigned w = 0; w < words; w++) begin
			beat.flag_word = '0;
			for (int unsigned b = 0; b < WORD_BITS; b++) begin
				if (w * WORD_BITS + b < n && side_hot[w * WORD_BITS + b]) begin
					beat.flag_word[b] = 1'b1;
				end
			end
			beat.word_index = WIDX_W'(w);
			beat.hot_count = HCNT_W'(hot_total);
			beat.last_word = (w + 1 == words);
			flag_expect_q.push_back(beat);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_STRIPS; i++) begin
				side_occ[i] = '0;
				side_hot[i] = 1'b0;
			end
			load_count = 0;
			cfg_strips = RST_STRIPS_IN_USE;
			cfg_sector = RST_SECTOR_SIZE;
			cfg_abs = RST_ABS_THRESHOLD;
			cfg_rel = RST_REL_FACTOR;
			flag_expect_q.delete();
			mismatch_count = 0;
			flags_pending = 0;
			sides_judged = 0;
			words_checked = 0;
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[APB_ADDR_W-1:2])
						REG_STRIPS_IN_USE: cfg_strips = pwdata[CFG_W-1:0];
						REG_SECTOR_SIZE:   cfg_sector = pwdata[CFG_W-1:0];
						REG_ABS_THRESHOLD: cfg_abs = pwdata[THR_W-1:0];
						REG_REL_FACTOR:    cfg_rel = pwdata[THR_W-1:0];
						default: ;
					endcase
				end else begin
					case (paddr[APB_ADDR_W-1:2])
						REG_STRIPS_IN_USE: reg_readback = APB_DATA_W'(cfg_strips);
						REG_SECTOR_SIZE:   reg_readback = APB_DATA_W'(cfg_sector);
						REG_ABS_THRESHOLD: reg_readback = APB_DATA_W'(cfg_abs);
						default:           reg_readback = APB_DATA_W'(cfg_rel);
					endcase
					check_field("prdata", 64'(reg_readback), 64'(prdata));
				end
			end
			if (strip_valid && strip_ready) begin
				if (load_count < MAX_STRIPS) begin
					side_occ[load_count] = strip.occupancy;
					load_count++;
				end
				if (strip.last_strip) begin
					judge_side();
					load_count = 0;
					sides_judged++;
				end
			end
			if (flag_valid && flag_ready) begin
				words_checked++;
				if (flag_expect_q.size() == 0) begin
					$error("flag beat with nothing expected: word_index %0d, flag_word 0x%0h",
						flag.word_index, flag.flag_word);
					mismatch_count++;
				end else begin
					want = flag_expect_q.pop_front();
					check_field("flag_word", want.flag_word, flag.flag_word);
					check_field("word_index", 64'(want.word_index), 64'(flag.word_index));
					check_field("hot_count", 64'(want.hot_count), 64'(flag.hot_count));
					check_field("last_word", 64'(want.last_word), 64'(flag.last_word));
				end
			end
			flags_pending = flag_expect_q.size();
		end
	end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hot strip finder testbench top
// Drives strip beats and register settings into the hot strip finder, stalls
// and idles both channels, and reports the verdict from the flag checker. A
// few hand-made sides cover the corner cases, one long side stores every strip
// that later sides read, and short random sides with random settings follow.
// ----------------------------------------------------------------------------
module tb_top;
	import hsif_pkg::*;

	localparam int STALL_LIMIT  = 5000000;
	localparam int HOLD_OFF     = 3000;
	localparam int QUIET_CYCLES = 100;
	localparam int RANDOM_ITEMS = 140;
	localparam int FILL_STRIPS  = 128;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  strip_valid = 1'b0;
	logic                  strip_ready;
	strip_t                strip = '0;
	logic                  flag_valid;
	logic                  flag_ready = 1'b0;
	flag_t                 flag;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int unsigned mismatch_count;
	int unsigned flags_pending;
	int unsigned sides_judged;
	int unsigned words_checked;
	int unsigned send_idle = 16;
	int unsigned recv_idle = 56;
	int unsigned hold_req = 0;
	int unsigned strips_sent = 0;
	int unsigned settings_done = 0;
	int unsigned stall_cycles;

	hot_strip_iterative_finder_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.strip_valid (strip_valid),
		.strip_ready (strip_ready),
		.strip       (strip),
		.flag_valid  (flag_valid),
		.flag_ready  (flag_ready),
		.flag        (flag),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	hsif_flag_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.strip_valid    (strip_valid),
		.strip_ready    (strip_ready),
		.strip          (strip),
		.flag_valid     (flag_valid),
		.flag_ready     (flag_ready),
		.flag           (flag),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.mismatch_count (mismatch_count),
		.flags_pending  (flags_pending),
		.sides_judged   (sides_judged),
		.words_checked  (words_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [OCC_W-1:0] pick_occupancy();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 20) return '0;
		if (r < 55) return OCC_W'($urandom_range(3000, 50));
		if (r < 75) return OCC_W'($urandom_range(25000, 3000));
		if (r < 95) return OCC_W'($urandom_range(65535));
		return '1;
	endfunction

	task automatic send_strip(input logic [OCC_W-1:0] occ, input logic last);
		while ($urandom_range(99) < send_idle) begin
			strip_valid <= 1'b0;
			@(posedge clk);
		end
		strip_valid <= 1'b1;
		strip <= '{occupancy: occ, last_strip: last};
		do @(posedge clk); while (!strip_ready);
		strips_sent++;
	endtask

	task automatic send_side(input int unsigned count);
		for (int unsigned i = 0; i < count; i++) begin
			send_strip(pick_occupancy(), i + 1 == count);
		end
	endtask

	task automatic wait_drained();
		strip_valid <= 1'b0;
		do @(posedge clk); while (flags_pending != 0);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [1:0] idx,
			input logic [APB_DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input int unsigned n, input int unsigned sector,
			input int unsigned abs_cut, input int unsigned rel);
		wait_drained();
		apb_access(1'b1, REG_STRIPS_IN_USE, n);
		apb_access(1'b1, REG_SECTOR_SIZE, sector);
		apb_access(1'b1, REG_ABS_THRESHOLD, abs_cut);
		apb_access(1'b1, REG_REL_FACTOR, rel);
		apb_access(1'b0, REG_STRIPS_IN_USE, '0);
		apb_access(1'b0, REG_SECTOR_SIZE, '0);
		apb_access(1'b0, REG_ABS_THRESHOLD, '0);
		apb_access(1'b0, REG_REL_FACTOR, '0);
		settings_done++;
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (hold_req != 0) begin
				flag_ready <= 1'b0;
				repeat (hold_req) @(posedge clk);
				hold_req = 0;
			end else begin
				flag_ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	initial begin
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((strip_valid && strip_ready) || (flag_valid && flag_ready) ||
					(psel && penable && pready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
		end
		$display("tb_top: errors");
		$finish;
	end

	initial begin : stimulus
		int unsigned rand_items;
		int unsigned n_pick;
		int unsigned sector_pick;
		int unsigned abs_pick;
		int unsigned rel_pick;
		int unsigned r;
		rand_items = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// A side of zero strips still gives one empty flag beat.
		set_config(0, 0, RST_ABS_THRESHOLD, RST_REL_FACTOR);
		send_strip(16'hFFFF, 1'b1);

		// Zero sector size covers the whole side; only the relative cut can fire.
		set_config(8, 0, 16'hFFFF, RST_REL_FACTOR);
		send_strip(16'd0, 1'b0);
		send_strip(16'hFFFF, 1'b0);
		repeat (5) send_strip(16'd100, 1'b0);
		send_strip(16'd0, 1'b1);

		// An empty sector, a full sector, and a partial tail that sees only the absolute cut.
		set_config(12, 5, 30000, 0);
		repeat (5) send_strip(16'd0, 1'b0);
		send_strip(16'd1, 1'b0);
		send_strip(16'd20000, 1'b0);
		send_strip(16'd30000, 1'b0);
		send_strip(16'd30001, 1'b0);
		send_strip(16'hFFFF, 1'b0);
		send_strip(16'd29999, 1'b0);
		send_strip(16'd12, 1'b1);

		// Sector larger than the side, and a short side that reuses stored strips.
		set_config(12, 20, 0, 16'hFFFF);
		send_strip(16'd0, 1'b0);
		send_strip(16'd1, 1'b0);
		send_strip(16'hFFFF, 1'b1);

		// The receiver holds off while later sides queue up behind the first.
		set_config(12, 4, 20000, 640);
		hold_req = HOLD_OFF;
		send_side(6);
		send_side(6);
		send_side(6);

		// One long side stores every strip that the random sides below may read.
		set_config(FILL_STRIPS, 16, 20000, 384);
		send_side(FILL_STRIPS);

		while (rand_items < RANDOM_ITEMS) begin
			if (rand_items < RANDOM_ITEMS / 3) begin
				send_idle = 16;
				recv_idle = 56;
			end else if (rand_items < 2 * RANDOM_ITEMS / 3) begin
				send_idle = 56;
				recv_idle = 16;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			if (rand_items == 0 || $urandom_range(2) == 0) begin
				r = $urandom_range(99);
				if (r < 40) n_pick = FILL_STRIPS;
				else if (r < 70) n_pick = $urandom_range(FILL_STRIPS, FILL_STRIPS / 2);
				else n_pick = $urandom_range(FILL_STRIPS - 1, 1);
				r = $urandom_range(99);
				if (r < 15) sector_pick = 0;
				else if (r < 30) sector_pick = n_pick;
				else if (r < 40) sector_pick = $urandom_range(4, 1);
				else if (r < 50) sector_pick = $urandom_range(1023, n_pick + 1);
				else if (r < 55) sector_pick = 1023;
				else sector_pick = $urandom_range(n_pick / 2, 8);
				r = $urandom_range(99);
				if (r < 10) abs_pick = 0;
				else if (r < 20) abs_pick = 16'hFFFF;
				else if (r < 60) abs_pick = $urandom_range(40000, 10000);
				else abs_pick = $urandom_range(65535);
				r = $urandom_range(99);
				if (r < 10) rel_pick = 0;
				else if (r < 20) rel_pick = 16'hFFFF;
				else if (r < 30) rel_pick = 256;
				else if (r < 45) rel_pick = RST_REL_FACTOR;
				else if (r < 85) rel_pick = $urandom_range(2048, 128);
				else rel_pick = $urandom_range(65535);
				set_config(n_pick, sector_pick, abs_pick, rel_pick);
			end
			r = $urandom_range(16, 1);
			send_side(r);
			rand_items += r;
		end

		wait_drained();
		$display("summary: %0d strip beats over %0d sides, %0d flag beats compared",
			strips_sent, sides_judged, words_checked);
		$display("summary: %0d register settings, from an empty side to one-strip sectors",
			settings_done);
		if (mismatch_count == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/hsif_pkg.sv
hw/rtl/hsif_ram.sv
hw/rtl/hsif_mul_cmp.sv
hw/rtl/hot_strip_iterative_finder_core.sv
tb/sv/hsif_flag_checker.sv
tb/sv/tb_top.sv
